>>> sv/u8xs_pkg.sv
// u8xs_pkg: shared types, constants and character-class functions for the
// utf-8 / xml character sanitizer. no dependencies.
package u8xs_pkg;

    localparam int unsigned MAX_SEQ_LEN = 6;
    localparam int unsigned SEEN_W      = 3;
    localparam int unsigned CODE_W      = 31;

    localparam logic [7:0] TAB_BYTE  = 8'h09;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // one run of results caused by a single input byte
    typedef struct packed {
        logic [MAX_SEQ_LEN-1:0][7:0] bytes;
        logic [SEEN_W-1:0]           count;
        logic                        present;
        logic                        eos;
    } run_t;

    function automatic logic [SEEN_W-1:0] lead_len(input logic [7:0] b);
        logic [SEEN_W-1:0] len;
        begin
            if (b < 8'h80)      len = 3'd1;
            else if (b < 8'hC0) len = 3'd0;
            else if (b < 8'hE0) len = 3'd2;
            else if (b < 8'hF0) len = 3'd3;
            else if (b < 8'hF8) len = 3'd4;
            else if (b < 8'hFC) len = 3'd5;
            else if (b < 8'hFE) len = 3'd6;
            else                len = 3'd0;
            return len;
        end
    endfunction

    function automatic logic is_ctrl(input logic [7:0] b);
        begin
            return (b <= 8'h08) || (b == 8'h0B) || (b == 8'h0C) ||
                   (b >= 8'h0E && b <= 8'h1F);
        end
    endfunction

    function automatic logic code_ok(input logic [CODE_W-1:0] c);
        logic ok;
        begin
            ok = ((c >= 31'h20 && c <= 31'hD7FF) || (c >= 31'hE000 && c <= 31'hFFFD) ||
                  c == 31'h9 || c == 31'hA || c == 31'hD ||
                  (c >= 31'h10000 && c <= 31'h10FFFF));
            if ((c >= 31'h7F && c <= 31'h84) || (c >= 31'h86 && c <= 31'h9F))
                ok = 1'b0;
            if (c >= 31'hFDD0 && c <= 31'hFDEF)
                ok = 1'b0;
            // last two code points of each supplementary plane
            if (c >= 31'h1FFFE && c <= 31'h10FFFF && c[15:1] == 15'h7FFF)
                ok = 1'b0;
            return ok;
        end
    endfunction

endpackage

>>> sv/u8xs_decoder.sv
// u8xs_decoder: sequence state, byte buffer and per-byte run builder.
// depends on u8xs_pkg.
module u8xs_decoder
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          string_end,
    output logic          run_valid,
    output u8xs_pkg::run_t run
);
    import u8xs_pkg::*;

    logic [SEEN_W-1:0] exp_reg, exp_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [CODE_W-1:0] acc_reg, acc_next;
    logic [MAX_SEQ_LEN-1:0][7:0] pend_reg;

    logic              pend_we;
    logic [SEEN_W-1:0] pend_idx;
    logic              cont;
    logic [SEEN_W-1:0] seen_inc;
    logic [CODE_W-1:0] acc_inc;
    logic [SEEN_W-1:0] len;
    logic [SEEN_W-1:0] cnt;

    always_comb
    begin
        exp_next  = exp_reg;
        seen_next = seen_reg;
        acc_next  = acc_reg;
        pend_we   = 1'b0;
        pend_idx  = seen_reg;
        cnt       = '0;
        run       = '0;
        run.present = 1'b1;
        len       = lead_len(in_byte);
        seen_inc  = seen_reg + 3'd1;
        acc_inc   = {acc_reg[CODE_W-7:0], in_byte[5:0]};
        cont      = (exp_reg != '0) && ((in_byte & CONT_MASK) == CONT_TAG) &&
                    (seen_reg < SEEN_W'(MAX_SEQ_LEN));

        if (cont)
        begin
            pend_we   = 1'b1;
            seen_next = seen_inc;
            acc_next  = acc_inc;
            if (seen_inc >= exp_reg)
            begin
                exp_next  = '0;
                seen_next = '0;
                acc_next  = '0;
                if (code_ok(acc_inc))
                begin
                    cnt = seen_inc;
                    for (int i = 0; i < MAX_SEQ_LEN; i++)
                        run.bytes[i] = (SEEN_W'(i) == seen_reg) ? in_byte : pend_reg[i];
                end
            end
        end
        else
        begin
            // broken sequence is dropped and this byte taken as a new lead
            exp_next  = '0;
            seen_next = '0;
            acc_next  = '0;
            if (is_ctrl(in_byte))
            begin
                cnt          = 3'd1;
                run.bytes[0] = TAB_BYTE;
            end
            else if (len == 3'd1)
            begin
                if (code_ok({24'd0, in_byte[6:0]}))
                begin
                    cnt          = 3'd1;
                    run.bytes[0] = in_byte;
                end
            end
            else if (len >= 3'd2)
            begin
                exp_next  = len;
                seen_next = 3'd1;
                acc_next  = {23'd0, in_byte & (8'h7F >> len)};
                pend_we   = 1'b1;
                pend_idx  = '0;
            end
        end

        if (string_end)
        begin
            exp_next  = '0;
            seen_next = '0;
            acc_next  = '0;
            run.eos   = 1'b1;
            if (cnt == '0)
            begin
                // bare end marker
                cnt         = 3'd1;
                run.bytes   = '0;
                run.present = 1'b0;
            end
        end

        run.count = cnt;
        run_valid = accept && (cnt != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= '0;
            seen_reg <= '0;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            seen_reg <= seen_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pend_we)
            pend_reg[pend_idx] <= in_byte;
    end

endmodule

>>> sv/utf8_xml_char_sanitizer.sv
// result path: runs are registered in the run queue and sent from its head.
// throughput: one byte per cycle while the run queue (of two) is not full and
// each byte yields at most one result; a byte of n results sends n beats.
// reset: rst_n clears the sequence state and empties the run queue; the
// byte buffer keeps no reset value.
module utf8_xml_char_sanitizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       byte_present,
    output logic       run_last,
    output logic       end_of_string
);
    import u8xs_pkg::*;

    localparam int unsigned QDEPTH = 2;

    logic   in_acc;
    logic   run_valid;
    run_t   run;
    run_t   q_reg [QDEPTH];
    logic   wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic [SEEN_W-1:0] idx_reg;
    run_t   head;
    logic   out_acc;
    logic   last_beat;
    logic   push, pop;

    assign byte_stall = (cnt_reg == 2'(QDEPTH));
    assign in_acc     = byte_valid && !byte_stall;

    u8xs_decoder u_dec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_acc),
        .in_byte    (in_byte),
        .string_end (string_end),
        .run_valid  (run_valid),
        .run        (run)
    );

    assign head          = q_reg[rd_ptr_reg];
    assign result_valid  = (cnt_reg != 2'd0);
    assign last_beat     = (idx_reg == head.count - 3'd1);
    assign out_byte      = head.bytes[idx_reg];
    assign byte_present  = head.present;
    assign run_last      = last_beat;
    assign end_of_string = last_beat && head.eos;

    assign out_acc  = result_valid && !result_stall;
    assign push     = run_valid;
    assign pop      = out_acc && last_beat;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                idx_reg    <= '0;
            end
            else if (out_acc)
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= run;
    end

`ifndef SYNTHESIS
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_present |-> out_byte == 8'h00 && run_last && end_of_string)
        else $error("end marker malformed");

    a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !run_last |=> result_valid)
        else $error("run broken by a bubble");

    a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && string_end |=> cnt_reg != 2'd0)
        else $error("string end left nothing queued");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH))
        else $error("run queue overflow");
`endif

endmodule
